// ===== design/bqd_pkg.sv =====
// ----------------------------------------------------------------------------
// bqd_pkg: shared types and constants of the biquad filter
// Fixed-point formats, digit sizes, register indexes and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bqd_pkg;

	// Word widths of the fixed-point data path.
	localparam int SAMPLE_W = 24;            // Q1.23 audio samples
	localparam int COEF_W   = 32;            // Q4.28 coefficients
	localparam int DATA_W   = 32;            // Q8.24 delay values
	localparam int ACC_W    = 64;            // Q.50 accumulator
	localparam int DIGIT_W  = 4;             // multiplier digit per cycle
	localparam int DIGITS   = DATA_W / DIGIT_W;
	localparam int CNT_W    = $clog2(DIGITS);
	localparam int TERM_W   = COEF_W + DIGIT_W + 1;
	localparam int CIDX_W   = 3;             // configuration index width

	// Product alignment and rounding.
	localparam int PROD_SH  = 2;             // Q.52 to Q.50
	localparam int X_SH     = 27;            // Q1.23 to Q.50
	localparam int W_SH     = 26;            // Q.50 to Q.24
	localparam int Y_SH     = 27;            // Q.50 to Q.23
	localparam logic signed [ACC_W-1:0] W_RND = 64'sd33554432;   // half LSB of w
	localparam logic signed [ACC_W-1:0] Y_RND = 64'sd67108864;   // half LSB of y

	// Reset value of b0 (1.0 in Q4.28).
	localparam logic signed [COEF_W-1:0] B0_RESET = 32'sh1000_0000;

	// Configuration register indexes.
	typedef enum logic [CIDX_W-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_A1 = 3'd3,
		REG_A2 = 3'd4
	} reg_idx_t;

	// Multiply-accumulate operations, in the order they run.
	typedef enum logic [2:0] {
		OP_A1 = 3'd0,
		OP_A2 = 3'd1,
		OP_B0 = 3'd2,
		OP_B1 = 3'd3,
		OP_B2 = 3'd4
	} op_t;

endpackage

`default_nettype wire

// ===== design/bqd_mul.sv =====
// ----------------------------------------------------------------------------
// bqd_mul: digit-serial signed multiplier
// Multiplies a Q4.28 coefficient by a Q8.24 operand, four operand bits per
// cycle, most significant digit first, and holds the exact 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_mul (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [bqd_pkg::COEF_W-1:0]    coef,
	input  wire logic signed [bqd_pkg::DATA_W-1:0]    opnd,
	output logic signed [bqd_pkg::ACC_W-1:0]          product,
	output logic                                      done
);

	localparam logic [bqd_pkg::CNT_W-1:0] LAST_DIGIT =
		bqd_pkg::CNT_W'(bqd_pkg::DIGITS - 1);

	logic                                       busy_q;
	logic                                       done_q;
	logic [bqd_pkg::CNT_W-1:0]                  cnt_q;
	logic signed [bqd_pkg::COEF_W-1:0]          coef_q;
	logic [bqd_pkg::DATA_W-1:0]                 opnd_q;
	logic signed [bqd_pkg::ACC_W-1:0]           prod_q;

	logic                                       sign_ext;
	logic signed [bqd_pkg::DIGIT_W:0]           digit;
	logic signed [bqd_pkg::TERM_W-1:0]          term;
	logic signed [bqd_pkg::ACC_W-1:0]           prod_next;

	// Only the leading digit carries the operand's sign; the rest are unsigned.
	assign sign_ext = (cnt_q == '0) & opnd_q[bqd_pkg::DATA_W-1];
	assign digit    = {sign_ext, opnd_q[bqd_pkg::DATA_W-1 -: bqd_pkg::DIGIT_W]};

	always_comb begin
		term = $signed({{(bqd_pkg::TERM_W-bqd_pkg::COEF_W){coef_q[bqd_pkg::COEF_W-1]}}, coef_q})
			* $signed({{(bqd_pkg::TERM_W-bqd_pkg::DIGIT_W-1){digit[bqd_pkg::DIGIT_W]}}, digit});
		prod_next = (prod_q <<< bqd_pkg::DIGIT_W)
			+ $signed({{(bqd_pkg::ACC_W-bqd_pkg::TERM_W){term[bqd_pkg::TERM_W-1]}}, term});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + bqd_pkg::CNT_W'(1);
				if (cnt_q == LAST_DIGIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			coef_q <= coef;
			opnd_q <= opnd;
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= prod_next;
			opnd_q <= opnd_q << bqd_pkg::DIGIT_W;
		end
	end

	assign product = prod_q;
	assign done    = done_q;

endmodule

`default_nettype wire

// ===== design/biquad_iir_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_iir_filter: second-order IIR section, direct form II, fixed point
// Schedule: one sample at a time. Its five products run through a single
// digit-serial multiplier; the S_RW step rounds w after the feedback products
// and S_RY rounds y after the rest. The idle state takes the next beat. A
// stalled output beat holds the last step.
// Reset: arst_n clears the delay line, restores the coefficients to b0 = 1.0
// and the rest 0, and empties the output register. No clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Configuration write port.
	input  wire logic                                   cfg_we,
	input  wire logic [bqd_pkg::CIDX_W-1:0]             cfg_index,
	input  wire logic [bqd_pkg::COEF_W-1:0]             cfg_data,
	// Input channel.
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [bqd_pkg::SAMPLE_W-1:0]    sample_in,
	input  wire logic                                   block_last,
	// Output channel.
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [bqd_pkg::SAMPLE_W-1:0]         sample_out,
	output logic                                        out_last,
	output logic                                        clipped
);

	// The sequencer walks one sample through its five products. Each product
	// takes a start step in S_START and then waits in S_MUL for the multiplier;
	// the result is folded into the accumulator on the cycle the multiplier reports done.
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_START = 5'b00010,
		S_MUL   = 5'b00100,
		S_RW    = 5'b01000,
		S_RY    = 5'b10000
	} state_t;

	state_t                                   state_q;
	bqd_pkg::op_t                             op_q;

	// Coefficient registers.
	logic signed [bqd_pkg::COEF_W-1:0]        b0_q, b1_q, b2_q, a1_q, a2_q;

	// Delay line and working registers.
	logic signed [bqd_pkg::DATA_W-1:0]        w1_q, w2_q, w_q;
	logic signed [bqd_pkg::ACC_W-1:0]         acc_q;
	logic                                     last_q;
	logic                                     clip_q;

	// Output register.
	logic                                     out_valid_q;
	logic signed [bqd_pkg::SAMPLE_W-1:0]      out_sample_q;
	logic                                     out_last_q;
	logic                                     out_clip_q;

	// Multiplier hookup.
	logic                                     mul_start;
	logic signed [bqd_pkg::COEF_W-1:0]        mul_coef;
	logic signed [bqd_pkg::DATA_W-1:0]        mul_opnd;
	logic signed [bqd_pkg::ACC_W-1:0]         mul_prod;
	logic                                     mul_done;
	logic signed [bqd_pkg::ACC_W-1:0]         prod_sh;
	logic                                     op_sub;

	// Rounding and saturation.
	logic signed [bqd_pkg::ACC_W-1:0]         rw_sum, rw_sh, ry_sum, ry_sh;
	logic                                     w_ovf, y_ovf;
	logic signed [bqd_pkg::DATA_W-1:0]        w_sat;
	logic signed [bqd_pkg::SAMPLE_W-1:0]      y_sat;

	logic                                     in_beat;
	logic                                     out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_beat   = in_valid & in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign mul_start = (state_q == S_START);

	// Operand selection per operation. The feedback terms are subtracted.
	always_comb begin
		unique case (op_q)
			bqd_pkg::OP_A1: begin
				mul_coef = a1_q;
				mul_opnd = w1_q;
				op_sub   = 1'b1;
			end
			bqd_pkg::OP_A2: begin
				mul_coef = a2_q;
				mul_opnd = w2_q;
				op_sub   = 1'b1;
			end
			bqd_pkg::OP_B0: begin
				mul_coef = b0_q;
				mul_opnd = w_q;
				op_sub   = 1'b0;
			end
			bqd_pkg::OP_B1: begin
				mul_coef = b1_q;
				mul_opnd = w1_q;
				op_sub   = 1'b0;
			end
			bqd_pkg::OP_B2: begin
				mul_coef = b2_q;
				mul_opnd = w2_q;
				op_sub   = 1'b0;
			end
			default: begin
				mul_coef = '0;
				mul_opnd = '0;
				op_sub   = 1'b0;
			end
		endcase
	end

	bqd_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.coef    (mul_coef),
		.opnd    (mul_opnd),
		.product (mul_prod),
		.done    (mul_done)
	);

	// Each product is floored to Q.50 on its own before it is summed.
	assign prod_sh = mul_prod >>> bqd_pkg::PROD_SH;

	// Round half up, then saturate. The shifted sum fits the target width
	// exactly when all bits from the target's sign bit upward agree.
	always_comb begin
		rw_sum = acc_q + bqd_pkg::W_RND;
		rw_sh  = rw_sum >>> bqd_pkg::W_SH;
		w_ovf  = !((&rw_sh[bqd_pkg::ACC_W-1:bqd_pkg::DATA_W-1])
			|| !(|rw_sh[bqd_pkg::ACC_W-1:bqd_pkg::DATA_W-1]));
		if (w_ovf) begin
			w_sat = rw_sh[bqd_pkg::ACC_W-1]
				? {1'b1, {(bqd_pkg::DATA_W-1){1'b0}}}
				: {1'b0, {(bqd_pkg::DATA_W-1){1'b1}}};
		end else begin
			w_sat = rw_sh[bqd_pkg::DATA_W-1:0];
		end

		ry_sum = acc_q + bqd_pkg::Y_RND;
		ry_sh  = ry_sum >>> bqd_pkg::Y_SH;
		y_ovf  = !((&ry_sh[bqd_pkg::ACC_W-1:bqd_pkg::SAMPLE_W-1])
			|| !(|ry_sh[bqd_pkg::ACC_W-1:bqd_pkg::SAMPLE_W-1]));
		if (y_ovf) begin
			y_sat = ry_sh[bqd_pkg::ACC_W-1]
				? {1'b1, {(bqd_pkg::SAMPLE_W-1){1'b0}}}
				: {1'b0, {(bqd_pkg::SAMPLE_W-1){1'b1}}};
		end else begin
			y_sat = ry_sh[bqd_pkg::SAMPLE_W-1:0];
		end
	end

	// Coefficient writes. Indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= bqd_pkg::B0_RESET;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bqd_pkg::REG_B0: b0_q <= cfg_data;
				bqd_pkg::REG_B1: b1_q <= cfg_data;
				bqd_pkg::REG_B2: b2_q <= cfg_data;
				bqd_pkg::REG_A1: a1_q <= cfg_data;
				bqd_pkg::REG_A2: a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, delay line and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= bqd_pkg::OP_A1;
			w1_q        <= '0;
			w2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In the last step the output register is reloaded below instead.
			if (out_valid_q && out_ready && state_q != S_RY) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						op_q    <= bqd_pkg::OP_A1;
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mul_done) begin
						unique case (op_q)
							bqd_pkg::OP_A1: begin
								op_q    <= bqd_pkg::OP_A2;
								state_q <= S_START;
							end
							bqd_pkg::OP_A2: state_q <= S_RW;
							bqd_pkg::OP_B0: begin
								op_q    <= bqd_pkg::OP_B1;
								state_q <= S_START;
							end
							bqd_pkg::OP_B1: begin
								op_q    <= bqd_pkg::OP_B2;
								state_q <= S_START;
							end
							bqd_pkg::OP_B2: state_q <= S_RY;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RW: begin
					op_q    <= bqd_pkg::OP_B0;
					state_q <= S_START;
				end
				S_RY: begin
					// Hold the finished sample until the output register frees up.
					if (out_free) begin
						out_valid_q <= 1'b1;
						w2_q        <= w1_q;
						w1_q        <= w_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Data path registers without reset.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			acc_q  <= {{(bqd_pkg::ACC_W-bqd_pkg::SAMPLE_W-bqd_pkg::X_SH)
				{sample_in[bqd_pkg::SAMPLE_W-1]}},
				sample_in, {bqd_pkg::X_SH{1'b0}}};
			last_q <= block_last;
			clip_q <= 1'b0;
		end else if (state_q == S_MUL && mul_done) begin
			acc_q <= op_sub ? (acc_q - prod_sh) : (acc_q + prod_sh);
		end else if (state_q == S_RW) begin
			w_q    <= w_sat;
			clip_q <= clip_q | w_ovf;
			acc_q  <= '0;
		end
		if (state_q == S_RY && out_free) begin
			out_sample_q <= y_sat;
			out_last_q   <= last_q;
			out_clip_q   <= clip_q | y_ovf;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_sample_q;
	assign out_last   = out_last_q;
	assign clipped    = out_clip_q;

endmodule

`default_nettype wire

// ===== design/bqd_checker.sv =====
// ----------------------------------------------------------------------------
// bqd_checker: port-level checks of the biquad filter
// Watches the handshakes and the output payload over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_ready,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_ready,
	input  wire logic signed [bqd_pkg::SAMPLE_W-1:0]  sample_out,
	input  wire logic                                 out_last,
	input  wire logic                                 clipped
);

	// No result is offered while reset is applied.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// One sample at a time: after an input beat the filter is busy.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again right after an input beat");

	// A new result appears exactly as the filter goes back to taking input.
	a_result_ends_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result offered while the filter is still busy");

	// A stalled output beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out)
			&& $stable(out_last) && $stable(clipped))
		else $error("output beat changed while stalled");

endmodule

bind biquad_iir_filter bqd_checker u_bqd_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the biquad IIR filter section
// Drives samples through the valid/ready input channel and checks every
// output beat against a bit-exact direct form II predictor or a fixed table
// value. The predictor keeps its own coefficient copy and delay line. A
// directed table comes first. It covers the identity filter after reset,
// coefficient extremes, delay-line and output saturation, and writes to
// unused register indexes. Random phases follow, each with new coefficients
// and one of four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	// Run length and timing limits.
	localparam int RND_PHASES    = 12;
	localparam int RND_PER_PHASE = 102;
	localparam int MAX_REST      = 20;      // longest idle streak on either side
	localparam int TAIL_CYCLES   = 64;      // watch time for stray beats after the last result
	localparam int CYCLE_LIMIT   = 600000;
	localparam int MAX_REPORTS   = 10;

	// Register indexes that no register answers to.
	localparam logic [bqd_pkg::CIDX_W-1:0] IDX_UNUSED_FIRST = 3'd5;
	localparam logic [bqd_pkg::CIDX_W-1:0] IDX_UNUSED_LAST  = 3'd7;

	// Saturation bounds of the delay value (Q8.24) and of the output (Q1.23).
	localparam longint W_HI = 2147483647;
	localparam longint W_LO = -W_HI - 1;
	localparam longint Y_HI = 8388607;
	localparam longint Y_LO = -Y_HI - 1;

	typedef struct packed {
		logic [bqd_pkg::SAMPLE_W-1:0] value;
		logic                         last;
		logic                         clip;
	} filt_out_t;

	// A beat is checked against the predictor, or against a value typed into the table.
	typedef enum logic {CHK_MODEL, CHK_FIXED} chk_t;

	typedef struct packed {
		logic [bqd_pkg::SAMPLE_W-1:0] smp;
		logic                         last;
		chk_t                         chk;
		filt_out_t                    fixed;
	} sample_beat_t;

	typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

	typedef struct packed {
		row_kind_t                    kind;
		logic [bqd_pkg::CIDX_W-1:0]   idx;
		logic [bqd_pkg::COEF_W-1:0]   data;
		sample_beat_t                 beat;
	} dir_row_t;

	typedef enum logic [1:0] {STYLE_FULL, STYLE_MILD, STYLE_EDGE} coef_style_t;

	// DUT connections. Every input is at a known level from time zero.
	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b1;
	logic                          cfg_we     = 1'b0;
	logic [bqd_pkg::CIDX_W-1:0]    cfg_index  = '0;
	logic [bqd_pkg::COEF_W-1:0]    cfg_data   = '0;
	logic                          in_valid   = 1'b0;
	logic                          in_ready;
	logic [bqd_pkg::SAMPLE_W-1:0]  sample_in  = '0;
	logic                          block_last = 1'b0;
	logic                          out_valid;
	logic                          out_ready  = 1'b0;
	logic [bqd_pkg::SAMPLE_W-1:0]  sample_out;
	logic                          out_last;
	logic                          clipped;

	// Bench state.
	sample_beat_t         pending_samples [$];   // waiting to be offered
	filt_out_t            expected_out [$];      // predicted, waiting for the DUT
	dir_row_t             dir_rows [$];
	sample_beat_t         cur_beat   = '0;       // the beat currently offered
	logic                 in_took    = 1'b0;     // input beat accepted at the last edge
	logic                 cfg_open   = 1'b0;     // write enable left high by write_reg
	int                   send_pct   = 0;        // chance of a sender gap per cycle
	int                   recv_pct   = 0;        // chance of a receiver stall per cycle
	int                   send_streak = 0;
	int                   recv_streak = 0;
	int                   errors     = 0;
	int                   cycle_cnt  = 0;

	// Predictor copy of the coefficients and of the delay line.
	logic signed [bqd_pkg::COEF_W-1:0] shadow_coef [5];
	logic signed [bqd_pkg::DATA_W-1:0] pred_w1 = '0;
	logic signed [bqd_pkg::DATA_W-1:0] pred_w2 = '0;

	biquad_iir_filter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.block_last (block_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.out_last   (out_last),
		.clipped    (clipped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Coefficient times delay value: exact in Q.52, floored to Q.50.
	function automatic longint prod50(input logic signed [bqd_pkg::COEF_W-1:0] c,
			input logic signed [bqd_pkg::DATA_W-1:0] d);
		return (longint'(c) * longint'(d)) >>> bqd_pkg::PROD_SH;
	endfunction

	// One step of the filter. It returns the output beat and advances the delay line.
	function automatic filt_out_t filter_sample(
			input logic signed [bqd_pkg::SAMPLE_W-1:0] x, input logic last);
		longint acc;
		longint w_full;
		longint y_full;
		logic signed [bqd_pkg::DATA_W-1:0] w_sat;
		filt_out_t res;
		res.clip = 1'b0;
		res.last = last;
		// Feedback half: w = x - a1*w1 - a2*w2, all in Q.50.
		acc = longint'(x) <<< bqd_pkg::X_SH;
		acc = acc - prod50(shadow_coef[bqd_pkg::REG_A1], pred_w1)
			- prod50(shadow_coef[bqd_pkg::REG_A2], pred_w2);
		w_full = (acc + bqd_pkg::W_RND) >>> bqd_pkg::W_SH;
		if (w_full > W_HI) begin
			w_full = W_HI;
			res.clip = 1'b1;
		end else if (w_full < W_LO) begin
			w_full = W_LO;
			res.clip = 1'b1;
		end
		w_sat = w_full[bqd_pkg::DATA_W-1:0];
		// Feedforward half uses the saturated w and the old delay values.
		acc = prod50(shadow_coef[bqd_pkg::REG_B0], w_sat)
			+ prod50(shadow_coef[bqd_pkg::REG_B1], pred_w1)
			+ prod50(shadow_coef[bqd_pkg::REG_B2], pred_w2);
		y_full = (acc + bqd_pkg::Y_RND) >>> bqd_pkg::Y_SH;
		if (y_full > Y_HI) begin
			y_full = Y_HI;
			res.clip = 1'b1;
		end else if (y_full < Y_LO) begin
			y_full = Y_LO;
			res.clip = 1'b1;
		end
		res.value = y_full[bqd_pkg::SAMPLE_W-1:0];
		pred_w2 = pred_w1;
		pred_w1 = w_sat;
		return res;
	endfunction

	function automatic void dir_cfg(input logic [bqd_pkg::CIDX_W-1:0] idx,
			input logic [bqd_pkg::COEF_W-1:0] data);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx  = idx;
		r.data = data;
		dir_rows.push_back(r);
	endfunction

	function automatic void dir_beat(input logic [bqd_pkg::SAMPLE_W-1:0] smp,
			input logic last, input chk_t chk,
			input logic [bqd_pkg::SAMPLE_W-1:0] val = '0, input logic clip = 1'b0);
		dir_row_t r;
		r = '0;
		r.kind             = ROW_BEAT;
		r.beat.smp         = smp;
		r.beat.last        = last;
		r.beat.chk         = chk;
		r.beat.fixed.value = val;
		r.beat.fixed.last  = last;
		r.beat.fixed.clip  = clip;
		dir_rows.push_back(r);
	endfunction

	// Random sample: mostly full-scale noise, some rail, zero or minus-one values, some quiet signal.
	function automatic sample_beat_t random_beat();
		sample_beat_t b;
		logic [31:0] rnd;
		int pick;
		b = '0;
		b.chk = CHK_MODEL;
		rnd = $urandom;
		pick = $urandom_range(99);
		if (pick < 60) begin
			b.smp = rnd[bqd_pkg::SAMPLE_W-1:0];
		end else if (pick < 75) begin
			case (rnd[1:0])
				2'd0: b.smp = 24'h7FFFFF;
				2'd1: b.smp = 24'h800000;
				2'd2: b.smp = 24'h000000;
				default: b.smp = 24'hFFFFFF;
			endcase
		end else begin
			b.smp = bqd_pkg::SAMPLE_W'(int'($urandom_range(131072)) - 65536);
		end
		b.last = ($urandom_range(7) == 0);
		return b;
	endfunction

	// Coefficient for one register. The mild style keeps the poles near a usable
	// range, so that long stretches run without saturating the delay line.
	function automatic logic [bqd_pkg::COEF_W-1:0] pick_coef(input coef_style_t style,
			input logic [bqd_pkg::CIDX_W-1:0] idx);
		int span;
		case (style)
			STYLE_MILD: begin
				if (idx == bqd_pkg::REG_A2) span = 241591910;        // about 0.9
				else if (idx == bqd_pkg::REG_A1) span = 268435456;   // 1.0
				else span = 536870912;                               // 2.0
				return bqd_pkg::COEF_W'(int'($urandom_range(2 * span)) - span);
			end
			STYLE_EDGE: begin
				case ($urandom_range(5))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					4: return 32'h0000_0001;
					default: return bqd_pkg::B0_RESET;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Blocks until nothing is queued, offered or expected, so the DUT is idle.
	task automatic wait_drained();
		while (pending_samples.size() != 0 || in_valid || expected_out.size() != 0)
			@(negedge clk);
	endtask

	// Drives the write enable high with the new data. Consecutive
	// calls keep the enable high; cfg_port_release lowers it.
	task automatic write_reg(input logic [bqd_pkg::CIDX_W-1:0] idx,
			input logic [bqd_pkg::COEF_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_open  = 1'b1;
		if (idx <= bqd_pkg::REG_A2)
			shadow_coef[idx] = data;
	endtask

	task automatic cfg_port_release();
		@(negedge clk);
		cfg_we   <= 1'b0;
		cfg_open = 1'b0;
	endtask

	// Input driver. A new beat is loaded only when the slot is free, so valid and
	// payload hold steady until the DUT takes the beat.
	always @(negedge clk) begin : drive_in
		logic rest;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			rest = (send_streak < MAX_REST) && ($urandom_range(99) < send_pct);
			if (pending_samples.size() != 0 && !rest) begin
				send_streak = 0;
				cur_beat   <= pending_samples[0];
				sample_in  <= pending_samples[0].smp;
				block_last <= pending_samples[0].last;
				in_valid   <= 1'b1;
				void'(pending_samples.pop_front());
			end else begin
				if (rest)
					send_streak = send_streak + 1;
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure, redrawn every cycle with a cap on streak length.
	always @(negedge clk) begin : drive_ready
		logic rest;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rest = (recv_streak < MAX_REST) && ($urandom_range(99) < recv_pct);
			recv_streak = rest ? recv_streak + 1 : 0;
			out_ready <= !rest;
		end
	end

	// Monitor. Accepted inputs run through the predictor, and accepted outputs
	// are compared against the oldest prediction, field by field.
	always @(posedge clk) begin : monitor
		filt_out_t pred;
		filt_out_t got;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				pred = filter_sample(cur_beat.smp, cur_beat.last);
				if (cur_beat.chk == CHK_FIXED)
					pred = cur_beat.fixed;
				expected_out.push_back(pred);
			end
			if (out_valid && out_ready) begin
				got.value = sample_out;
				got.last  = out_last;
				got.clip  = clipped;
				if (expected_out.size() == 0) begin
					errors = errors + 1;
					if (errors <= MAX_REPORTS)
						$display("unexpected output beat: %0d last %0b clip %0b",
							$signed(got.value), got.last, got.clip);
				end else begin
					pred = expected_out.pop_front();
					if (got.value !== pred.value || got.last !== pred.last
							|| got.clip !== pred.clip) begin
						errors = errors + 1;
						if (errors <= MAX_REPORTS)
							$display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
								$signed(pred.value), pred.last, pred.clip,
								$signed(got.value), got.last, got.clip);
					end
				end
			end
		end
	end

	// Watchdog over the whole run.
	always @(posedge clk) begin
		cycle_cnt = cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Reset is applied once, just after time zero, and released on a falling edge.
	initial begin
		#1 arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin : stimulus
		coef_style_t style;
		// Reset values of the coefficient copy: a pass-through filter.
		shadow_coef[bqd_pkg::REG_B0] = bqd_pkg::B0_RESET;
		shadow_coef[bqd_pkg::REG_B1] = '0;
		shadow_coef[bqd_pkg::REG_B2] = '0;
		shadow_coef[bqd_pkg::REG_A1] = '0;
		shadow_coef[bqd_pkg::REG_A2] = '0;

		// With the reset coefficients the filter is exactly the identity, so
		// each output equals its input and nothing clips.
		dir_beat(24'h000000, 1'b0, CHK_FIXED, 24'h000000, 1'b0);
		dir_beat(24'h7FFFFF, 1'b1, CHK_FIXED, 24'h7FFFFF, 1'b0);
		dir_beat(24'h800000, 1'b0, CHK_FIXED, 24'h800000, 1'b0);
		dir_beat(24'h000001, 1'b0, CHK_FIXED, 24'h000001, 1'b0);
		dir_beat(24'hFFFFFF, 1'b1, CHK_FIXED, 24'hFFFFFF, 1'b0);
		dir_beat(24'h555555, 1'b0, CHK_FIXED, 24'h555555, 1'b0);
		dir_beat(24'hAAAAAA, 1'b1, CHK_FIXED, 24'hAAAAAA, 1'b0);
		// Largest positive gain: full-scale inputs hit the output rails.
		dir_cfg(bqd_pkg::REG_B0, 32'h7FFF_FFFF);
		dir_beat(24'h7FFFFF, 1'b0, CHK_FIXED, 24'h7FFFFF, 1'b1);
		dir_beat(24'h800000, 1'b1, CHK_FIXED, 24'h800000, 1'b1);
		dir_beat(24'h000000, 1'b0, CHK_FIXED, 24'h000000, 1'b0);
		// Largest negative gain flips the sign and saturates the other way.
		dir_cfg(bqd_pkg::REG_B0, 32'h8000_0000);
		dir_beat(24'h7FFFFF, 1'b0, CHK_FIXED, 24'h800000, 1'b1);
		dir_beat(24'h800000, 1'b0, CHK_FIXED, 24'h7FFFFF, 1'b1);
		// An unstable section whose delay values grow and drive the output into saturation.
		dir_cfg(bqd_pkg::REG_B0, bqd_pkg::B0_RESET);
		dir_cfg(bqd_pkg::REG_B1, 32'h2000_0000);
		dir_cfg(bqd_pkg::REG_B2, 32'hF000_0000);
		dir_cfg(bqd_pkg::REG_A1, 32'hE000_0000);
		dir_cfg(bqd_pkg::REG_A2, 32'h0C00_0000);
		dir_beat(24'h400000, 1'b0, CHK_MODEL);
		dir_beat(24'h000000, 1'b0, CHK_MODEL);
		dir_beat(24'hC00000, 1'b1, CHK_MODEL);
		dir_beat(24'h123456, 1'b0, CHK_MODEL);
		// All feedback terms and the b1, b2 feedforward terms at their extremes.
		dir_cfg(bqd_pkg::REG_A1, 32'h8000_0000);
		dir_cfg(bqd_pkg::REG_A2, 32'h7FFF_FFFF);
		dir_cfg(bqd_pkg::REG_B1, 32'h7FFF_FFFF);
		dir_cfg(bqd_pkg::REG_B2, 32'h8000_0000);
		dir_beat(24'h7FFFFF, 1'b0, CHK_MODEL);
		dir_beat(24'h800000, 1'b1, CHK_MODEL);
		dir_beat(24'h000001, 1'b0, CHK_MODEL);
		dir_beat(24'h7FFFFF, 1'b0, CHK_MODEL);
		// Writes to unused indexes must leave every coefficient alone.
		dir_cfg(IDX_UNUSED_FIRST, 32'hFFFF_FFFF);
		dir_cfg(IDX_UNUSED_FIRST + 3'd1, 32'h0000_0000);
		dir_cfg(IDX_UNUSED_LAST, 32'h5A5A_5A5A);
		dir_beat(24'h000100, 1'b0, CHK_MODEL);
		dir_beat(24'hFFFF00, 1'b1, CHK_MODEL);
		dir_beat(24'h000000, 1'b0, CHK_MODEL);

		@(posedge arst_n);

		// Directed part, no idling. Register rows wait until the DUT is empty.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				if (cfg_open)
					cfg_port_release();
				pending_samples.push_back(dir_rows[i].beat);
			end
		end

		// Random phases. The coefficient style and the idling pattern cycle
		// with different periods, so every pairing of the two comes up.
		for (int ph = 0; ph < RND_PHASES; ph++) begin
			wait_drained();
			style = coef_style_t'(ph % 3);
			case (ph % 4)
				0: begin
					send_pct = 0;
					recv_pct = 0;
				end
				1: begin
					send_pct = 80;
					recv_pct = 0;
				end
				2: begin
					send_pct = 0;
					recv_pct = 80;
				end
				default: begin
					send_pct = 31;
					recv_pct = 31;
				end
			endcase
			for (int r = bqd_pkg::REG_B0; r <= bqd_pkg::REG_A2; r++)
				write_reg(bqd_pkg::CIDX_W'(r), pick_coef(style, bqd_pkg::CIDX_W'(r)));
			if ($urandom_range(2) == 0)
				write_reg(IDX_UNUSED_FIRST + bqd_pkg::CIDX_W'($urandom_range(2)), $urandom);
			cfg_port_release();
			repeat (RND_PER_PHASE)
				pending_samples.push_back(random_beat());
		end

		// Let the last results come out, then watch for stray beats a while.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
design/bqd_pkg.sv
design/bqd_mul.sv
design/biquad_iir_filter.sv
design/bqd_checker.sv
tb/tb_top.sv
